[rtl/core/sfd_pkg.sv]
// Shared constants for the stereo feedback delay: register map, field widths,
// reset values and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

    // Parameter defaults
    localparam int SFD_MAX_DELAY   = 16384;
    localparam int SFD_CHANNELS    = 2;
    localparam int SFD_SAMPLE_BITS = 24;

    // Q1.15 fractions
    localparam int          Q_FRAC_BITS = 15;
    localparam int          FRAC_W      = 16;
    localparam logic [15:0] Q_ONE       = 16'h8000;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DELAY_LEN_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd3;

    localparam logic [FRAC_W-1:0]      GAIN_RST         = 16'd32768;
    localparam logic [FRAC_W-1:0]      FEEDBACK_RST     = 16'd11469;
    localparam logic [FRAC_W-1:0]      MIX_RST          = 16'd16384;
    localparam logic [DELAY_LEN_W-1:0] DELAY_LENGTH_RST = 15'd9600;

endpackage

[rtl/core/sfd_in_if.sv]
// Input channel of the stereo feedback delay: valid/ready plus one tagged sample.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

interface sfd_in_if import sfd_pkg::*; #(
    parameter int SAMPLE_BITS = SFD_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

[rtl/core/sfd_out_if.sv]
// Output channel of the stereo feedback delay: valid/ready plus one result sample.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

interface sfd_out_if import sfd_pkg::*; #(
    parameter int SAMPLE_BITS = SFD_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic                          out_channel;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output out_channel, output sample_out, input ready);
    modport sink   (input valid, input out_channel, input sample_out, output ready);
endinterface

[rtl/core/sfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
    parameter  int WIDTH  = 24,
    parameter  int DEPTH  = 32768,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/stereo_feedback_delay.sv]
// Stereo feedback delay (echo comb filter) top level.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if and sfd_ram.
`timescale 1ns / 1ps

// Each input transaction carries one signed sample and a channel tag; each channel owns
// a ring of delay_length samples in a shared RAM (CHANNELS * MAX_DELAY words). The
// stored word is scaled by feedback to form the delayed value, dry + delayed is written
// back saturated, and the result is (dry*(1-mix) + delayed*mix) * gain, floor-shifted
// by 15 and saturated. All fractions are unsigned Q1.15 and clamp at 1.0; delay_length
// 0 acts as 1 and values above MAX_DELAY act as MAX_DELAY. Timing: after reset the
// RAM is swept to zero, one word per cycle, over all CHANNELS * MAX_DELAY words (32768
// with the defaults), during which no input is taken. After that a sample is taken only in
// idle and then passes through RD for the registered RAM read and six steps M1 to M6 through
// the single registered multiplier, which forms the four products one after another.
// The result sits in an output register, so the next
// sample is accepted while it waits; the block stalls only if a second result is ready
// before the first one has been taken. Configuration writes are taken on any cycle and
// are meant to happen while the block is idle.
module stereo_feedback_delay import sfd_pkg::*; #(
    parameter int MAX_DELAY   = SFD_MAX_DELAY,
    parameter int CHANNELS    = SFD_CHANNELS,
    parameter int SAMPLE_BITS = SFD_SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sfd_in_if.sink                i_in,
    sfd_out_if.source             o_out
);

    localparam int SB     = SAMPLE_BITS;
    localparam int DEPTH  = CHANNELS * MAX_DELAY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(MAX_DELAY);
    localparam int LEN_W  = ($clog2(MAX_DELAY + 1) > DELAY_LEN_W) ?
                            $clog2(MAX_DELAY + 1) : DELAY_LEN_W;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = SB + FRAC_W + 2;   // (SB+1) x (FRAC_W+1) signed
    localparam int ACC_W  = PROD_W + 1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6
    } t_state;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [FRAC_W-1:0]      r_gain, r_feedback, r_mix;
    logic [DELAY_LEN_W-1:0] r_delay_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain         <= GAIN_RST;
            r_feedback     <= FEEDBACK_RST;
            r_mix          <= MIX_RST;
            r_delay_length <= DELAY_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN:         r_gain         <= i_cfg_data;
                REG_FEEDBACK:     r_feedback     <= i_cfg_data;
                REG_MIX:          r_mix          <= i_cfg_data;
                REG_DELAY_LENGTH: r_delay_length <= i_cfg_data[DELAY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Fractions above 1.0 clamp to 1.0
    logic [FRAC_W-1:0] fb, mx, gn, dry_w;
    assign fb    = (r_feedback > Q_ONE) ? Q_ONE : r_feedback;
    assign mx    = (r_mix > Q_ONE) ? Q_ONE : r_mix;
    assign gn    = (r_gain > Q_ONE) ? Q_ONE : r_gain;
    assign dry_w = Q_ONE - mx;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state                r_state;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [POS_W-1:0]      r_pos [CHANNELS];
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_ch_field;
    logic signed [SB-1:0]  r_dry;
    logic signed [SB-1:0]  r_delayed;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                  r_out_valid;
    logic                  r_out_ch;
    logic signed [SB-1:0]  r_out_sample;

    logic in_accept;
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;

    // ---------------------------------------------------------------
    // Ring addressing for the incoming transaction
    // ---------------------------------------------------------------
    logic [CH_W-1:0]   ch_idx;
    logic [LEN_W-1:0]  dl_ext, len, pos_cur, pos_use, pos_inc;
    logic [POS_W-1:0]  pos_nx;
    logic [ADDR_W-1:0] base;

    // A one-bit tag is always below CHANNELS when there are two or more channels
    assign ch_idx = (CHANNELS > 1) ? CH_W'(i_in.channel) : '0;
    assign dl_ext = LEN_W'(r_delay_length);

    always_comb begin
        if (dl_ext == '0) begin
            len = LEN_W'(1);
        end else if (dl_ext > LEN_W'(MAX_DELAY)) begin
            len = LEN_W'(MAX_DELAY);
        end else begin
            len = dl_ext;
        end
    end

    // A position left beyond a shortened ring restarts at zero
    assign pos_cur = LEN_W'(r_pos[ch_idx]);
    assign pos_use = (pos_cur >= len) ? '0 : pos_cur;
    assign pos_inc = pos_use + LEN_W'(1);
    assign pos_nx  = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];

    always_comb begin
        base = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (ch_idx == CH_W'(c)) base = ADDR_W'(c * MAX_DELAY);
        end
    end

    // ---------------------------------------------------------------
    // Shared multiplier, operands picked by step
    // ---------------------------------------------------------------
    function automatic logic signed [SB-1:0] sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] smax, smin;
        smax = PROD_W'({1'b0, {(SB-1){1'b1}}});
        smin = -smax - PROD_W'(1);
        if (v > smax)      sat = smax[SB-1:0];
        else if (v < smin) sat = smin[SB-1:0];
        else               sat = v[SB-1:0];
    endfunction

    logic [SB-1:0]            ram_rdata;
    logic signed [SB:0]       mul_a;
    logic signed [FRAC_W:0]   mul_b;
    logic                     mul_en;
    logic signed [SB-1:0]     prod_q;    // product floor-shifted back to a sample
    logic signed [SB-1:0]     mixed;
    logic signed [SB:0]       wb_sum;
    logic signed [PROD_W-1:0] res_shift;

    assign prod_q    = r_prod[SB+Q_FRAC_BITS-1:Q_FRAC_BITS];
    assign mixed     = r_acc[SB+Q_FRAC_BITS-1:Q_FRAC_BITS];
    assign wb_sum    = {r_dry[SB-1], r_dry} + {prod_q[SB-1], prod_q};
    assign res_shift = r_prod >>> Q_FRAC_BITS;

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            ST_M1: begin   // stored word * feedback
                mul_a = {ram_rdata[SB-1], ram_rdata};
                mul_b = {1'b0, fb};
            end
            ST_M2: begin   // dry * (1 - mix)
                mul_a = {r_dry[SB-1], r_dry};
                mul_b = {1'b0, dry_w};
            end
            ST_M3: begin   // delayed * mix
                mul_a = {r_delayed[SB-1], r_delayed};
                mul_b = {1'b0, mx};
            end
            ST_M5: begin   // mixed * gain
                mul_a = {mixed[SB-1], mixed};
                mul_b = {1'b0, gn};
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= mul_a * mul_b;
    end

    // ---------------------------------------------------------------
    // Delay RAM: clearing sweep after reset, write-back in step M2
    // ---------------------------------------------------------------
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SB-1:0]     ram_wdata;

    assign ram_re    = (r_state == ST_RD);
    assign ram_we    = (r_state == ST_CLEAR) || (r_state == ST_M2);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_addr;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 :
                       sat({{(PROD_W-SB-1){wb_sum[SB]}}, wb_sum});

    sfd_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer, datapath registers and output register
    // ---------------------------------------------------------------
    logic out_load;
    assign out_load = (r_state == ST_M6) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) r_pos[c] <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_pos[ch_idx] <= pos_nx;
                        r_state       <= ST_RD;
                    end
                end
                ST_RD: r_state <= ST_M1;
                ST_M1: r_state <= ST_M2;
                ST_M2: r_state <= ST_M3;
                ST_M3: r_state <= ST_M4;
                ST_M4: r_state <= ST_M5;
                ST_M5: r_state <= ST_M6;
                ST_M6: begin
                    if (out_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr     <= base + ADDR_W'(pos_use);
            r_ch_field <= i_in.channel;
            r_dry      <= i_in.sample_in;
        end
        if (r_state == ST_M2) r_delayed <= prod_q;
        if (r_state == ST_M3) r_acc <= {r_prod[PROD_W-1], r_prod};
        if (r_state == ST_M4) r_acc <= r_acc + {r_prod[PROD_W-1], r_prod};
        if (out_load) begin
            r_out_ch     <= r_ch_field;
            r_out_sample <= sat(res_shift);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_ch;
    assign o_out.sample_out  = r_out_sample;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !i_in.ready)
        else $error("input still ready after a transaction was accepted");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_addr < ADDR_W'(DEPTH - 1)) || (r_addr == ADDR_W'(DEPTH - 1)))
        else $error("delay RAM address beyond the ring storage");

    a_result_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_M6))
        else $error("result presented without finishing the sequence");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) && (r_clr_addr == ADDR_W'(DEPTH - 1)) |=> r_state == ST_IDLE)
        else $error("clearing sweep did not end at the last word");

endmodule
